// File: hdl/hspd_pkg.sv
// Shared constants and elaboration-time helpers for the separated-parity
// Hamming decoder. No dependencies.
package hspd_pkg;

    // Fixed field widths of the data and check words
    localparam int DATA_W  = 32;
    localparam int CHECK_W = 7;
    localparam int SYN_W   = 7;

    // Number of check bits: smallest r with 2^r >= 2*n+2
    function automatic int check_count(input int n);
        int r;
        r = 0;
        while (r < 16 && (1 << r) < (2 * n + 2)) begin
            r = r + 1;
        end
        return r;
    endfunction

    // Data bits that exist in the word (positions 1..n, capped at DATA_W)
    function automatic logic [DATA_W-1:0] data_mask(input int n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int j = 0; j < DATA_W; j++) begin
            if (j < n) begin
                m[j] = 1'b1;
            end
        end
        return m;
    endfunction

    // Data bits covered by group parity k: position j+1 has bit k set
    function automatic logic [DATA_W-1:0] grp_mask(input int k, input int n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int j = 0; j < DATA_W; j++) begin
            if (j < n && (((j + 1) >> k) & 1) == 1) begin
                m[j] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: hdl/hspd_syndrome.sv
// Syndrome XOR trees for the separated-parity Hamming decoder.
// Depends on hspd_pkg.
module hspd_syndrome #(
    parameter int DATA_BITS = 32
) (
    input  logic [hspd_pkg::DATA_W-1:0]  i_data,
    input  logic [hspd_pkg::CHECK_W-1:0] i_check,
    output logic [hspd_pkg::SYN_W-1:0]   o_syn
);

    localparam int CHK_BITS = hspd_pkg::check_count(DATA_BITS);
    localparam logic [hspd_pkg::CHECK_W-1:0] CMASK =
        hspd_pkg::CHECK_W'((1 << CHK_BITS) - 1);

    // Group parities: check bit k against every covered data position
    for (genvar k = 0; k < CHK_BITS - 1; k++) begin : g_grp
        localparam logic [hspd_pkg::DATA_W-1:0] GMASK =
            hspd_pkg::grp_mask(k, DATA_BITS);
        assign o_syn[k] = i_check[k] ^ (^(i_data & GMASK));
    end

    // Top syndrome bit: parity over the valid check bits only
    assign o_syn[CHK_BITS-1] = ^(i_check & CMASK);

    // Syndrome bits above the check count stay zero
    for (genvar k = CHK_BITS; k < hspd_pkg::SYN_W; k++) begin : g_zero
        assign o_syn[k] = 1'b0;
    end

endmodule

// File: hdl/hamming_separated_parity_decoder_unit.sv
// Top level of the separated-parity Hamming single-error-correcting decoder.
// Depends on hspd_pkg and hspd_syndrome.
//
// One codeword beat per clock is accepted while the output is not stalled,
// and one result beat is returned for each, in order. The pipeline has three
// register stages: syndrome XOR trees, the position decode into a one-hot
// flip mask, and the correcting XOR into the output register. Each stage
// holds its own valid bit and advances whenever the stage after it is empty
// or moving, so back-pressure on the output stalls only as far as the
// pipeline is full. Data bits at and above DATA_BITS are ignored on input
// and read as zero on output.
module hamming_separated_parity_decoder_unit #(
    parameter int DATA_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: [31:0] data_word, [38:32] check_word, [39] zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // tdata: [31:0] corrected_data, [32] error_found, [39:33] syndrome_value,
    //        [40] data_bit_fixed, [47:41] zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata
);

    localparam int DW = hspd_pkg::DATA_W;
    localparam int SW = hspd_pkg::SYN_W;
    localparam logic [DW-1:0] DMASK   = hspd_pkg::data_mask(DATA_BITS);
    localparam logic [SW-1:0] SYN_MAX = SW'(DATA_BITS);

    // Stage ready chain
    logic w_rdy1, w_rdy2, w_rdy3;

    // Stage 1: masked data and syndrome
    logic          r_v1;
    logic [DW-1:0] r_d1;
    logic [SW-1:0] r_s1;
    logic [DW-1:0] w_din;
    logic [SW-1:0] w_syn;

    // Stage 2: flip mask and flags
    logic          r_v2;
    logic [DW-1:0] r_d2;
    logic [DW-1:0] r_m2;
    logic [SW-1:0] r_s2;
    logic          r_fix2;
    logic [DW-1:0] n_m2;

    // Stage 3: output register
    logic          r_v3;
    logic [DW-1:0] r_d3;
    logic [SW-1:0] r_s3;
    logic          r_err3;
    logic          r_fix3;

    assign w_rdy3 = !r_v3 || m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    assign w_din = s_axis_tdata[DW-1:0] & DMASK;

    hspd_syndrome #(
        .DATA_BITS (DATA_BITS)
    ) u_syn (
        .i_data  (w_din),
        .i_check (s_axis_tdata[DW+hspd_pkg::CHECK_W-1:DW]),
        .o_syn   (w_syn)
    );

    // One-hot flip mask: data bit j is wrong when the syndrome equals j+1
    always_comb begin
        for (int j = 0; j < DW; j++) begin
            n_m2[j] = (r_s1 == SW'(j + 1)) && DMASK[j];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_axis_tvalid) begin
            r_d1 <= w_din;
            r_s1 <= w_syn;
        end
        if (w_rdy2 && r_v1) begin
            r_d2   <= r_d1;
            r_m2   <= n_m2;
            r_s2   <= r_s1;
            r_fix2 <= (r_s1 != '0) && (r_s1 <= SYN_MAX);
        end
        if (w_rdy3 && r_v2) begin
            r_d3   <= r_d2 ^ r_m2;
            r_s3   <= r_s2;
            r_err3 <= (r_s2 != '0);
            r_fix3 <= r_fix2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {7'b0, r_fix3, r_s3, r_err3, r_d3};

endmodule

// File: hdl/hspd_checker.sv
// Port-level checker for hamming_separated_parity_decoder_unit, with bind.
// Depends on the top level's port list only.
module hspd_checker #(
    parameter int DATA_BITS = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // A stalled result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // Error flag tracks a nonzero syndrome
    a_err_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[39:33] != 7'd0)))
        else $error("error flag disagrees with syndrome");

    // A fix only happens for a syndrome that names a data position
    a_fix_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[40] ==
            (m_axis_tdata[39:33] != 7'd0 && m_axis_tdata[39:33] <= 7'(DATA_BITS))))
        else $error("fix flag disagrees with syndrome");

endmodule

bind hamming_separated_parity_decoder_unit hspd_checker #(
    .DATA_BITS (DATA_BITS)
) u_hspd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb.sv
// Self-checking bench for the separated-parity Hamming decoder unit.
// Needs hspd_pkg and hamming_separated_parity_decoder_unit with its submodules.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration and the check-bit count that follows from it
    localparam int DATA_BITS = 32;
    localparam int PAR_BITS  = hspd_pkg::check_count(DATA_BITS);  // smallest r, 2^r >= 2n+2

    // Output beat layout
    localparam int ERR_BIT = 32;
    localparam int SYN_LSB = 33;
    localparam int FIX_BIT = 40;

    localparam int IDLE_PCT       = 29;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [hspd_pkg::DATA_W-1:0] corrected;
        logic                        err;
        logic [hspd_pkg::SYN_W-1:0]  syn;
        logic                        fixed;
    } t_decode_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [31:0] data_word, [38:32] check_word, [39] pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;     // [31:0] corrected, [32] error, [39:33] syndrome,
                                   // [40] fixed, [47:41] pad

    t_decode_result pending_decodes[$];
    int  mismatch_count;
    int  words_sent;
    int  words_checked;
    int  flips_seen;
    int  unfixed_errors_seen;
    int  idle_cycles;
    bit  no_idle;

    hamming_separated_parity_decoder_unit #(
        .DATA_BITS(DATA_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Expected decode of one received codeword
    function automatic t_decode_result decode_codeword(
            input logic [hspd_pkg::DATA_W-1:0] data,
            input logic [hspd_pkg::CHECK_W-1:0] checks);
        t_decode_result              res;
        logic [hspd_pkg::DATA_W-1:0] keep;
        logic                        p;
        int                          k;
        int                          pos;
        keep = '0;
        for (pos = 0; pos < DATA_BITS && pos < hspd_pkg::DATA_W; pos++) begin
            keep[pos] = 1'b1;
        end
        data = data & keep;
        res.syn = '0;
        // group parities: check bit k over positions with bit k set
        for (k = 0; k < PAR_BITS - 1; k++) begin
            p = checks[k];
            for (pos = 1; pos <= DATA_BITS && pos <= hspd_pkg::DATA_W; pos++) begin
                if (((pos >> k) & 1) == 1) begin
                    p = p ^ data[pos-1];
                end
            end
            res.syn[k] = p;
        end
        // top syndrome bit: parity over all check bits
        res.syn[PAR_BITS-1] = ^checks[PAR_BITS-1:0];
        res.err       = (res.syn != 0);
        res.fixed     = 1'b0;
        res.corrected = data;
        if (res.syn != 0 && res.syn <= DATA_BITS) begin
            res.fixed = 1'b1;
            if (res.syn <= hspd_pkg::DATA_W) begin
                res.corrected[res.syn-1] = ~res.corrected[res.syn-1];
            end
        end
        return res;
    endfunction

    // Check bits that make a clean codeword for the given data
    function automatic logic [hspd_pkg::CHECK_W-1:0] hamming_checks(
            input logic [hspd_pkg::DATA_W-1:0] data);
        logic [hspd_pkg::CHECK_W-1:0] c;
        int                           k;
        int                           pos;
        c = '0;
        for (k = 0; k < PAR_BITS - 1; k++) begin
            for (pos = 1; pos <= DATA_BITS; pos++) begin
                if (((pos >> k) & 1) == 1) begin
                    c[k] = c[k] ^ data[pos-1];
                end
            end
        end
        c[PAR_BITS-1] = ^c[PAR_BITS-2:0];
        return c;
    endfunction

    // Drive one codeword beat, with random idle cycles ahead of it
    task automatic send_codeword(input logic [hspd_pkg::DATA_W-1:0] data,
                                 input logic [hspd_pkg::CHECK_W-1:0] checks);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, checks, data};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Clean codewords at the data extremes and one mixed pattern
    task automatic test_clean_words();
        send_codeword(32'h0000_0000, hamming_checks(32'h0000_0000));
        send_codeword(32'hFFFF_FFFF, hamming_checks(32'hFFFF_FFFF));
        send_codeword(32'hA5A5_5A5A, hamming_checks(32'hA5A5_5A5A));
    endtask

    // One flipped data bit, lowest and highest positions included
    task automatic test_single_data_errors();
        send_codeword(32'h0000_0001, hamming_checks(32'h0000_0000));
        send_codeword(32'h8000_0000, hamming_checks(32'h0000_0000));
        send_codeword(32'hFFFF_7FFF, hamming_checks(32'hFFFF_FFFF));
        send_codeword(32'h1234_56F8, hamming_checks(32'h1234_5678));
    endtask

    // One flipped check bit: names a position past the data
    task automatic test_check_bit_errors();
        logic [hspd_pkg::CHECK_W-1:0] c;
        c = hamming_checks(32'hDEAD_BEEF);
        send_codeword(32'hDEAD_BEEF, c ^ 7'b000_0001);
        send_codeword(32'hDEAD_BEEF, c ^ 7'b010_0000);
        send_codeword(32'hDEAD_BEEF, c ^ 7'b100_0000);
    endtask

    // Syndromes beyond the data and a double error
    task automatic test_uncorrectable_patterns();
        logic [hspd_pkg::CHECK_W-1:0] c;
        send_codeword(32'h0000_0000, 7'b010_0001);    // syndrome just past the data
        send_codeword(32'h0000_0000, 7'b011_1111);    // largest without overall bit
        send_codeword(32'h0000_0000, 7'b111_1111);    // all syndrome bits set
        c = hamming_checks(32'h1234_5678);
        send_codeword(32'h1234_5678 ^ 32'h0000_0401, c);
    endtask

    // Mostly real codewords with zero, one or two errors, some raw noise
    task automatic test_random_traffic(input int n_items);
        logic [hspd_pkg::DATA_W-1:0]                   d;
        logic [hspd_pkg::CHECK_W-1:0]                  c;
        logic [hspd_pkg::DATA_W+hspd_pkg::CHECK_W-1:0] cw;
        int                                            kind;
        int                                            a;
        int                                            b;
        for (int i = 0; i < n_items; i++) begin
            no_idle = (i >= n_items / 3) && (i < n_items / 3 + 200);
            d    = $urandom;
            c    = hamming_checks(d);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                a = $urandom_range(0, DATA_BITS - 1);
                d[a] = ~d[a];
            end else if (kind < 60) begin
                a = $urandom_range(0, PAR_BITS - 1);
                c[a] = ~c[a];
            end else if (kind < 72) begin
                cw = {c, d};
                a  = $urandom_range(0, hspd_pkg::DATA_W + hspd_pkg::CHECK_W - 1);
                b  = (a + $urandom_range(1, hspd_pkg::DATA_W + hspd_pkg::CHECK_W - 1))
                     % (hspd_pkg::DATA_W + hspd_pkg::CHECK_W);
                cw[a] = ~cw[a];
                cw[b] = ~cw[b];
                {c, d} = cw;
            end else if (kind < 85) begin
                c = hspd_pkg::CHECK_W'($urandom);
            end
            send_codeword(d, c);
        end
        no_idle = 1'b0;
    endtask

    // Output stall pattern
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Record accepted codewords and check each result beat against the oldest one
    always @(posedge i_clk) begin
        t_decode_result want;
        t_decode_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_decodes = {pending_decodes,
                                   decode_codeword(s_axis_tdata[31:0],
                                                   s_axis_tdata[38:32])};
                words_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.corrected = m_axis_tdata[31:0];
                got.err       = m_axis_tdata[ERR_BIT];
                got.syn       = m_axis_tdata[SYN_LSB+hspd_pkg::SYN_W-1:SYN_LSB];
                got.fixed     = m_axis_tdata[FIX_BIT];
                if (pending_decodes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result beat %h", $realtime, m_axis_tdata);
                    end
                end else begin
                    want = pending_decodes.pop_front();
                    words_checked++;
                    if (want.fixed) flips_seen++;
                    if (want.err && !want.fixed) unfixed_errors_seen++;
                    if (got.corrected !== want.corrected || got.err !== want.err ||
                        got.syn !== want.syn || got.fixed !== want.fixed) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] mismatch data exp %h got %h, err exp %b got %b",
                                     $realtime, want.corrected, got.corrected,
                                     want.err, got.err);
                            $display("      syndrome exp %0d got %0d, fixed exp %b got %b",
                                     want.syn, got.syn, want.fixed, got.fixed);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        s_axis_tvalid       = 1'b0;
        s_axis_tdata        = '0;
        no_idle             = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_clean_words();
        test_single_data_errors();
        test_check_bit_errors();
        test_uncorrectable_patterns();
        test_random_traffic(950);
        s_axis_tvalid <= 1'b0;

        // Let the pipeline empty, then watch for stray beats
        while (pending_decodes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d codewords (%0d checked): %0d data bits repaired,",
                 words_sent, words_checked, flips_seen);
        $display("%0d errors outside the data, %0d mismatches",
                 unfixed_errors_seen, mismatch_count);
        if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: hamming_separated_parity_decoder_unit.f
hdl/hspd_pkg.sv
hdl/hspd_syndrome.sv
hdl/hamming_separated_parity_decoder_unit.sv
hdl/hspd_checker.sv
bench/tb.sv
